[rtl/otp_pkg.sv]
// otp_pkg: types and constants shared by the one-shot timer pool.
// No dependencies. Used by otp_ctrl and one_shot_timer_pool.
`default_nettype none

package otp_pkg;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Fixed widths of the result fields
  localparam int unsigned ALLOC_W = 3;
  localparam int unsigned EMASK_W = 8;
  localparam int unsigned ECNT_W  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } otp_state_e;

  // One result beat
  typedef struct packed {
    logic               start_ok;
    logic [ALLOC_W-1:0] alloc_id;
    logic [EMASK_W-1:0] expired_mask;
    logic [ECNT_W-1:0]  expired_count;
  } otp_result_t;

endpackage

`default_nettype wire

[rtl/one_shot_timer_pool.sv]
// one_shot_timer_pool: top level; request engine plus output register.
// Depends on otp_pkg, otp_ctrl (and through it otp_ram).
//
//  channel  direction  handshake                 beat fields
//  in       input      in_valid_i / in_stall_o   req_type_i, duration_i, timer_id_i
//  out      output     out_valid_o / out_stall_i start_ok_o, alloc_id_o,
//                                                expired_mask_o, expired_count_o
//
// Start, stop and unused codes go from acceptance to the engine result register,
// then to the output register. A tick sweeps the count RAM one timer per cycle
// through its single read port, with each writeback in the cycle after its read.
// One request is in the engine at a time; the output register holds a finished
// beat while the next request is accepted.
// Reset clears the in-use mask at once; counts need no clearing.
// out_stall_i holds the result; the engine then waits with in_stall_o high.
`default_nettype none

module one_shot_timer_pool #(
  parameter int unsigned NUM_TIMERS  = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [15:0] duration_i,
  input  wire logic [3:0]  timer_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             start_ok_o,
  output logic [2:0]       alloc_id_o,
  output logic [7:0]       expired_mask_o,
  output logic [3:0]       expired_count_o
);

  logic                 eng_idle;
  logic                 eng_res_valid;
  logic                 slot_free;
  otp_pkg::otp_result_t eng_res;
  otp_pkg::otp_result_t out_res_q;
  logic                 out_vld_q, out_vld_d;

  otp_ctrl #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_type_i  (req_type_i),
    .duration_i  (duration_i),
    .timer_id_i  (timer_id_i),
    .idle_o      (eng_idle),
    .res_valid_o (eng_res_valid),
    .res_take_i  (slot_free),
    .res_o       (eng_res)
  );

  assign in_stall_o = !eng_idle;

  // output register: loads when empty or being drained
  assign slot_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (slot_free) begin
      out_vld_d = eng_res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && eng_res_valid) begin
      out_res_q <= eng_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign start_ok_o      = out_res_q.start_ok;
  assign alloc_id_o      = out_res_q.alloc_id;
  assign expired_mask_o  = out_res_q.expired_mask;
  assign expired_count_o = out_res_q.expired_count;

endmodule

`default_nettype wire

[rtl/otp_ram.sv]
// otp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module otp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/otp_ctrl.sv]
// otp_ctrl: request engine of the timer pool; in-use mask, count RAM, tick sweep.
// Depends on otp_pkg and otp_ram.
`default_nettype none

module otp_ctrl #(
  parameter int unsigned NUM_TIMERS  = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [15:0]        duration_i,
  input  wire logic [3:0]         timer_id_i,
  output logic                    idle_o,
  output logic                    res_valid_o,
  input  wire logic               res_take_i,
  output otp_pkg::otp_result_t    res_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(NUM_TIMERS);

  otp_pkg::otp_state_e  state_q, state_d;
  logic [NUM_TIMERS-1:0] in_use_q, in_use_d;
  logic [NUM_TIMERS-1:0] emask_q, emask_d;
  logic [CNT_W-1:0]      ecnt_q, ecnt_d;
  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  wb_vld_q, wb_vld_d;
  logic [IDX_W-1:0]      wb_idx_q, wb_idx_d;
  otp_pkg::otp_result_t  res_q, res_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   accept;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [31:0]            id_ext;
  logic                   stop_in_range;
  logic [IDX_W-1:0]       stop_idx;
  logic [31:0]            dur_ext;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [31:0]            alloc_ext, emask_ext, ecnt_ext;

  // count store
  otp_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_TIMERS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // lowest free timer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign id_ext        = 32'(timer_id_i);
  assign stop_in_range = id_ext < NUM_TIMERS;
  assign stop_idx      = id_ext[IDX_W-1:0];
  assign dur_ext       = 32'(duration_i);
  assign cnt_dec       = ram_rdata - COUNT_WIDTH'(1);
  assign alloc_ext     = 32'(free_idx);

  assign accept      = req_valid_i && (state_q == otp_pkg::ST_IDLE);
  assign idle_o      = (state_q == otp_pkg::ST_IDLE);
  assign res_valid_o = (state_q == otp_pkg::ST_DONE);
  assign res_o       = res_q;

  // next state, RAM access and result
  always_comb begin
    state_d   = state_q;
    in_use_d  = in_use_q;
    emask_d   = emask_q;
    ecnt_d    = ecnt_q;
    rd_idx_d  = rd_idx_q;
    wb_vld_d  = 1'b0;
    wb_idx_d  = wb_idx_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[IDX_W-1:0];
    emask_ext = '0;
    ecnt_ext  = '0;

    case (state_q)
      otp_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = otp_pkg::ST_DONE;
          case (req_type_i)
            otp_pkg::REQ_START: begin
              if (free_found) begin
                ram_we             = 1'b1;
                ram_waddr          = free_idx;
                ram_wdata          = dur_ext[COUNT_WIDTH-1:0];
                in_use_d[free_idx] = 1'b1;
                res_d.start_ok     = 1'b1;
                res_d.alloc_id     = alloc_ext[otp_pkg::ALLOC_W-1:0];
              end
            end
            otp_pkg::REQ_STOP: begin
              if (stop_in_range) begin
                ram_we             = 1'b1;
                ram_waddr          = stop_idx;
                in_use_d[stop_idx] = 1'b0;
              end
            end
            otp_pkg::REQ_TICK: begin
              state_d  = otp_pkg::ST_SWEEP;
              rd_idx_d = '0;
              emask_d  = '0;
              ecnt_d   = '0;
            end
            default: ;
          endcase
        end
      end

      // read timer k while writing back timer k-1
      otp_pkg::ST_SWEEP: begin
        if (rd_idx_q != SWEEP_END) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + CNT_W'(1);
          wb_vld_d = 1'b1;
          wb_idx_d = rd_idx_q[IDX_W-1:0];
        end
        if (wb_vld_q && in_use_q[wb_idx_q]) begin
          ram_we    = 1'b1;
          ram_waddr = wb_idx_q;
          ram_wdata = cnt_dec;
          if (cnt_dec == '0) begin
            in_use_d[wb_idx_q] = 1'b0;
            emask_d[wb_idx_q]  = 1'b1;
            ecnt_d             = ecnt_q + CNT_W'(1);
          end
        end
        if (rd_idx_q == SWEEP_END) begin
          emask_ext           = 32'(emask_d);
          ecnt_ext            = 32'(ecnt_d);
          res_d               = '0;
          res_d.expired_mask  = emask_ext[otp_pkg::EMASK_W-1:0];
          res_d.expired_count = ecnt_ext[otp_pkg::ECNT_W-1:0];
          state_d             = otp_pkg::ST_DONE;
        end
      end

      otp_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = otp_pkg::ST_IDLE;
        end
      end

      default: state_d = otp_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= otp_pkg::ST_IDLE;
      in_use_q <= '0;
      emask_q  <= '0;
      ecnt_q   <= '0;
      rd_idx_q <= '0;
      wb_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      emask_q  <= emask_d;
      ecnt_q   <= ecnt_d;
      rd_idx_q <= rd_idx_d;
      wb_vld_q <= wb_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    wb_idx_q <= wb_idx_d;
    res_q    <= res_d;
  end

  // sweep never reads the entry it writes back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("count RAM read and write hit the same entry");

  // writeback pipe is empty outside a sweep
  a_wb_only_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != otp_pkg::ST_SWEEP) |-> !wb_vld_q)
    else $error("writeback pending outside a sweep");

  // expiry count tracks the mask
  a_ecnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecnt_q) == $countones(emask_q))
    else $error("expiry count disagrees with expiry mask");

  // an accepted tick starts a fresh sweep
  a_tick_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == otp_pkg::REQ_TICK)
      |=> (state_q == otp_pkg::ST_SWEEP && rd_idx_q == '0 && emask_q == '0))
    else $error("tick did not start a clean sweep");

endmodule

`default_nettype wire
